>>> hw/rtl/lgp_pkg.sv
`default_nettype none
package lgp_pkg;

  localparam int COORD_BITS      = 12;
  localparam int ANGLE_FRAC_BITS = 14;
  localparam int T_FRAC_BITS     = 16;

  localparam int SIZE_W  = 13;
  localparam int ANGLE_W = 16;
  localparam int COLOR_W = 24;
  localparam int CH_W    = 8;

  // centered doubled coordinate, projection, magnitude and divider widths
  localparam int PT_W   = ((COORD_BITS + 1 > SIZE_W) ? COORD_BITS + 1 : SIZE_W) + 2;
  localparam int PROD_W = PT_W + ANGLE_W;
  localparam int D_W    = PROD_W + 1;
  localparam int M_W    = D_W - 1;
  localparam int R_W    = M_W + 1;
  localparam int S_W    = D_W + 1;
  localparam int T_W    = T_FRAC_BITS + 1;
  localparam int BL_W   = CH_W + T_FRAC_BITS + 2;

  localparam logic [M_W-1:0] M_ZERO_FIX = M_W'(2) << ANGLE_FRAC_BITS;
  localparam logic [T_W-1:0] T_ONE      = T_W'(1) << T_FRAC_BITS;

  localparam int IN_W  = ((2 * COORD_BITS + 7) / 8) * 8;
  localparam int OUT_W = 3 * CH_W;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = COLOR_W;

  localparam int FIFO_AW    = 5;
  localparam int FIFO_DEPTH = 1 << FIFO_AW;
  localparam int CNT_W      = FIFO_AW + 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH  = 3'd0,
    REG_HEIGHT = 3'd1,
    REG_START  = 3'd2,
    REG_END    = 3'd3,
    REG_COS    = 3'd4,
    REG_SIN    = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic                   vld;
    logic                   lo;
    logic                   hi;
    logic [R_W-1:0]         rem;
    logic [T_FRAC_BITS-1:0] quo;
  } lgp_cell_t;

endpackage
`default_nettype wire

>>> hw/rtl/lgp_div_cell.sv
`default_nettype none
module lgp_div_cell (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic [lgp_pkg::R_W-1:0] div,
  input  wire lgp_pkg::lgp_cell_t   c_i,
  output lgp_pkg::lgp_cell_t        c_o
);

  logic [lgp_pkg::R_W:0]   r2;
  logic                    ge;
  logic [lgp_pkg::R_W:0]   diff;
  lgp_pkg::lgp_cell_t      c_nxt;

  // one restoring step: shift in a zero, subtract when it fits
  always_comb begin
    r2    = {c_i.rem, 1'b0};
    ge    = r2 >= {1'b0, div};
    diff  = r2 - {1'b0, div};
    c_nxt = c_i;
    c_nxt.rem = ge ? diff[lgp_pkg::R_W-1:0] : r2[lgp_pkg::R_W-1:0];
    c_nxt.quo = {c_i.quo[lgp_pkg::T_FRAC_BITS-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_o.vld <= 1'b0;
    end else begin
      c_o.vld <= c_i.vld;
    end
    c_o.lo  <= c_nxt.lo;
    c_o.hi  <= c_nxt.hi;
    c_o.rem <= c_nxt.rem;
    c_o.quo <= c_nxt.quo;
  end

endmodule
`default_nettype wire

>>> hw/rtl/lgp_out_fifo.sv
`default_nettype none
module lgp_out_fifo (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       wr_en,
  input  wire logic [lgp_pkg::OUT_W-1:0]  wr_data,
  input  wire logic                       rd_en,
  output logic      [lgp_pkg::OUT_W-1:0]  rd_data,
  output logic                            empty
);

  logic [lgp_pkg::OUT_W-1:0]   mem [lgp_pkg::FIFO_DEPTH];
  logic [lgp_pkg::FIFO_AW:0]   wr_ptr_r;
  logic [lgp_pkg::FIFO_AW:0]   rd_ptr_r;
  logic [lgp_pkg::OUT_W-1:0]   head_r;
  logic                        head_vld_r;
  logic                        mem_empty;
  logic                        load;

  // move the oldest stored item into the head register when it is free or being read
  assign mem_empty = wr_ptr_r == rd_ptr_r;
  assign load      = !mem_empty && (!head_vld_r || rd_en);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
      head_vld_r <= 1'b0;
    end else begin
      if (wr_en) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (load) rd_ptr_r <= rd_ptr_r + 1'b1;
      if (load) begin
        head_vld_r <= 1'b1;
      end else if (rd_en) begin
        head_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_ptr_r[lgp_pkg::FIFO_AW-1:0]] <= wr_data;
    if (load) head_r <= mem[rd_ptr_r[lgp_pkg::FIFO_AW-1:0]];
  end

  assign rd_data = head_r;
  assign empty   = !head_vld_r;

endmodule
`default_nettype wire

>>> hw/rtl/linear_gradient_pixel_top.sv
// Channel | Direction | Handshake              | Payload
// in_     | slave     | in_tvalid / in_tready   | pixel_x, pixel_y
// out_    | master    | out_tvalid / out_tready | red, green, blue
// cfg_    | slave     | cfg_valid / cfg_ready   | register index, write data
//
// One pixel enters per clock while in_tready is high; its color passes
// through 4 front stages, one cell per quotient bit of t, one blend stage,
// the queue write and the queue head register.
// The row of divider cells is most of that path; rate stays one pixel per clock.
// rst_n is synchronous: it empties the pipeline and output queue and loads
// the register defaults. A stalled output fills a 32-entry queue; input is
// held off only once 32 items are accepted but not yet delivered.
`default_nettype none
module linear_gradient_pixel_top (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [lgp_pkg::IN_W-1:0]      in_tdata,   // pixel_x, pixel_y
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic      [lgp_pkg::OUT_W-1:0]     out_tdata,  // red, green, blue
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [lgp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [lgp_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int NCELL = lgp_pkg::T_FRAC_BITS;

  // ---------------- configuration registers
  logic [lgp_pkg::SIZE_W-1:0]         width_r, height_r;
  logic [lgp_pkg::COLOR_W-1:0]        start_r, end_r;
  logic signed [lgp_pkg::ANGLE_W-1:0] cos_r, sin_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= lgp_pkg::SIZE_W'(64);
      height_r <= lgp_pkg::SIZE_W'(64);
      start_r  <= '0;
      end_r    <= '1;
      cos_r    <= lgp_pkg::ANGLE_W'(16384);
      sin_r    <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        lgp_pkg::REG_WIDTH:  width_r  <= cfg_data[lgp_pkg::SIZE_W-1:0];
        lgp_pkg::REG_HEIGHT: height_r <= cfg_data[lgp_pkg::SIZE_W-1:0];
        lgp_pkg::REG_START:  start_r  <= cfg_data[lgp_pkg::COLOR_W-1:0];
        lgp_pkg::REG_END:    end_r    <= cfg_data[lgp_pkg::COLOR_W-1:0];
        lgp_pkg::REG_COS:    cos_r    <= cfg_data[lgp_pkg::ANGLE_W-1:0];
        lgp_pkg::REG_SIN:    sin_r    <= cfg_data[lgp_pkg::ANGLE_W-1:0];
        default: ;
      endcase
    end
  end

  // zero size counts as one pixel
  logic [lgp_pkg::SIZE_W-1:0] w_eff, h_eff;
  assign w_eff = (width_r  == '0) ? lgp_pkg::SIZE_W'(1) : width_r;
  assign h_eff = (height_r == '0) ? lgp_pkg::SIZE_W'(1) : height_r;

  // ---------------- span pipeline: largest |projection| over the corners.
  // Free running from the registers; products, magnitudes and span update
  // in turn after a write, before any pixel accepted after it needs them.
  logic signed [lgp_pkg::PT_W-1:0]   xl, xr, yt, yb;
  logic signed [lgp_pkg::PROD_W-1:0] cxl_r, cxr_r, syt_r, syb_r;
  logic signed [lgp_pkg::D_W-1:0]    k0, k1, k2, k3;
  logic [lgp_pkg::M_W-1:0]           a0_r, a1_r, a2_r, a3_r;
  logic [lgp_pkg::M_W-1:0]           mx01, mx23, mx;
  logic [lgp_pkg::M_W-1:0]           m_r;
  logic [lgp_pkg::R_W-1:0]           div_r;

  assign xl = -$signed(lgp_pkg::PT_W'(w_eff));
  assign xr = $signed(lgp_pkg::PT_W'(w_eff)) - lgp_pkg::PT_W'(2);
  assign yt = -$signed(lgp_pkg::PT_W'(h_eff));
  assign yb = $signed(lgp_pkg::PT_W'(h_eff)) - lgp_pkg::PT_W'(2);

  always_ff @(posedge clk) begin
    cxl_r <= lgp_pkg::PROD_W'(xl) * lgp_pkg::PROD_W'(cos_r);
    cxr_r <= lgp_pkg::PROD_W'(xr) * lgp_pkg::PROD_W'(cos_r);
    syt_r <= lgp_pkg::PROD_W'(yt) * lgp_pkg::PROD_W'(sin_r);
    syb_r <= lgp_pkg::PROD_W'(yb) * lgp_pkg::PROD_W'(sin_r);
  end

  assign k0 = lgp_pkg::D_W'(cxl_r) + lgp_pkg::D_W'(syt_r);
  assign k1 = lgp_pkg::D_W'(cxr_r) + lgp_pkg::D_W'(syt_r);
  assign k2 = lgp_pkg::D_W'(cxl_r) + lgp_pkg::D_W'(syb_r);
  assign k3 = lgp_pkg::D_W'(cxr_r) + lgp_pkg::D_W'(syb_r);

  always_ff @(posedge clk) begin
    a0_r <= k0[lgp_pkg::D_W-1] ? lgp_pkg::M_W'(-k0) : lgp_pkg::M_W'(k0);
    a1_r <= k1[lgp_pkg::D_W-1] ? lgp_pkg::M_W'(-k1) : lgp_pkg::M_W'(k1);
    a2_r <= k2[lgp_pkg::D_W-1] ? lgp_pkg::M_W'(-k2) : lgp_pkg::M_W'(k2);
    a3_r <= k3[lgp_pkg::D_W-1] ? lgp_pkg::M_W'(-k3) : lgp_pkg::M_W'(k3);
  end

  assign mx01 = (a0_r > a1_r) ? a0_r : a1_r;
  assign mx23 = (a2_r > a3_r) ? a2_r : a3_r;
  assign mx   = (mx01 > mx23) ? mx01 : mx23;

  always_ff @(posedge clk) begin
    m_r   <= (mx == '0) ? lgp_pkg::M_ZERO_FIX : mx;
    div_r <= (mx == '0) ? {lgp_pkg::M_ZERO_FIX, 1'b0} : {mx, 1'b0};
  end

  // ---------------- occupancy: items accepted and not yet delivered
  logic                      in_acc, out_acc;
  logic [lgp_pkg::CNT_W-1:0] cnt_r;

  assign in_tready = cnt_r < lgp_pkg::CNT_W'(lgp_pkg::FIFO_DEPTH);
  assign in_acc    = in_tvalid && in_tready;
  assign out_acc   = out_tvalid && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (in_acc && !out_acc) begin
      cnt_r <= cnt_r + 1'b1;
    end else if (out_acc && !in_acc) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  // ---------------- front stages: center, project, sum, set up divide
  logic [lgp_pkg::COORD_BITS-1:0]    pix_x, pix_y;
  logic                              v1_r, v2_r, v3_r;
  logic signed [lgp_pkg::PT_W-1:0]   px2_r, py2_r;
  logic signed [lgp_pkg::PROD_W-1:0] pc_r, ps_r;
  logic signed [lgp_pkg::D_W-1:0]    d_r;
  logic signed [lgp_pkg::S_W-1:0]    sum;
  logic                              lo, hi;
  lgp_pkg::lgp_cell_t                stage [NCELL+1];

  assign pix_x = in_tdata[lgp_pkg::COORD_BITS-1:0];
  assign pix_y = in_tdata[2*lgp_pkg::COORD_BITS-1:lgp_pkg::COORD_BITS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= in_acc;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
    px2_r <= $signed((lgp_pkg::PT_W'(pix_x) << 1) - lgp_pkg::PT_W'(w_eff));
    py2_r <= $signed((lgp_pkg::PT_W'(pix_y) << 1) - lgp_pkg::PT_W'(h_eff));
    pc_r  <= lgp_pkg::PROD_W'(px2_r) * lgp_pkg::PROD_W'(cos_r);
    ps_r  <= lgp_pkg::PROD_W'(py2_r) * lgp_pkg::PROD_W'(sin_r);
    d_r   <= lgp_pkg::D_W'(pc_r) + lgp_pkg::D_W'(ps_r);
  end

  // t saturates low when d + m <= 0 and high when d >= m
  assign sum = lgp_pkg::S_W'(d_r) + lgp_pkg::S_W'($signed({1'b0, m_r}));
  assign lo  = sum[lgp_pkg::S_W-1] || (sum == '0);
  assign hi  = d_r >= $signed({1'b0, m_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage[0].vld <= 1'b0;
    end else begin
      stage[0].vld <= v3_r;
    end
    stage[0].lo  <= lo;
    stage[0].hi  <= hi;
    stage[0].rem <= (lo || hi) ? '0 : sum[lgp_pkg::R_W-1:0];
    stage[0].quo <= '0;
  end

  // ---------------- row of divider cells, one quotient bit each
  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    lgp_div_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .div   (div_r),
      .c_i   (stage[i]),
      .c_o   (stage[i+1])
    );
  end

  // ---------------- blend: start*(1-t) + end*t, rounded
  logic [lgp_pkg::T_W-1:0]   t, tc;
  logic [lgp_pkg::OUT_W-1:0] rgb;
  logic [lgp_pkg::OUT_W-1:0] rgb_r;
  logic                      vb_r;
  logic [lgp_pkg::BL_W-1:0]  bl [3];

  assign t  = stage[NCELL].lo ? '0 :
              stage[NCELL].hi ? lgp_pkg::T_ONE : lgp_pkg::T_W'(stage[NCELL].quo);
  assign tc = lgp_pkg::T_ONE - t;

  for (genvar c = 0; c < 3; c++) begin : g_chan
    // channel c sits at byte 2-c of the packed color
    assign bl[c] = lgp_pkg::BL_W'(start_r[(2-c)*lgp_pkg::CH_W +: lgp_pkg::CH_W]) *
                   lgp_pkg::BL_W'(tc)
                 + lgp_pkg::BL_W'(end_r[(2-c)*lgp_pkg::CH_W +: lgp_pkg::CH_W]) *
                   lgp_pkg::BL_W'(t)
                 + (lgp_pkg::BL_W'(1) << (lgp_pkg::T_FRAC_BITS - 1));
    assign rgb[c*lgp_pkg::CH_W +: lgp_pkg::CH_W] =
      bl[c][lgp_pkg::T_FRAC_BITS +: lgp_pkg::CH_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else begin
      vb_r <= stage[NCELL].vld;
    end
    rgb_r <= rgb;
  end

  // ---------------- output queue; occupancy count keeps it from overflowing
  logic fifo_empty;

  lgp_out_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (vb_r),
    .wr_data (rgb_r),
    .rd_en   (out_acc),
    .rd_data (out_tdata),
    .empty   (fifo_empty)
  );

  assign out_tvalid = !fifo_empty;

  // ---------------- checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= lgp_pkg::CNT_W'(lgp_pkg::FIFO_DEPTH))
    else $error("occupancy beyond queue depth");

  a_out_has_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> cnt_r != '0)
    else $error("result shown with nothing in flight");

  a_span_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n, 3) |-> m_r != '0)
    else $error("zero span reached divider");

  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == '0 |-> !vb_r && fifo_empty)
    else $error("pipeline holds items while count is zero");

endmodule
`default_nettype wire
